FILE: hw/rtl/first_fit_page_run_allocator_defines.svh
// Assertion macros used by the checker of the page-run allocator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_DEFINES_SVH

// Clocked assertion that is switched off during reset.
`define FFPRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define FFPRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ffpra_pkg.sv
// Shared types and codes of the first-fit page-run allocator.
// No dependencies.
`default_nettype none

package ffpra_pkg;

  localparam int unsigned DivW = 24;
  localparam logic [22:0] ResultMax = 23'h7FFFFF;

  localparam logic [1:0] ModeAlloc = 2'd0;
  localparam logic [1:0] ModeFree  = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;

  localparam logic [1:0] StatusOk          = 2'd0;
  localparam logic [1:0] StatusAllocFail   = 2'd1;
  localparam logic [1:0] StatusFreeReject  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [22:0] size_bytes;
    logic [21:0] address;
  } req_t;

  typedef struct packed {
    logic [22:0] result_address;
    logic [1:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/first_fit_page_run_allocator.sv
// Top level of the first-fit page-run allocator: sequencer, page map and length store.
// Depends on ffpra_pkg.
//
//   channel | direction | handshake                | payload
//   request | in        | in_valid_i / in_stall_o  | in_req_i  (ffpra_pkg::req_t)
//   result  | out       | out_valid_o / out_stall_i| out_rsp_o (ffpra_pkg::rsp_t)
//
// Allocate counts pages by repeated addition of PAGE_BYTES, scans one page a cycle up to the end
// of the first fitting run and marks one page a cycle; free counts pages up to the address,
// reads the length store and releases the run one page a cycle; query scans every page.
// After reset the page map is cleared, page by page, before a request is taken.
// A finished result waits in the output register while the next request is accepted.
`default_nettype none

module first_fit_page_run_allocator #(
  parameter int unsigned PAGES           = 1024,
  parameter int unsigned PAGE_BYTES      = 4096,
  parameter int unsigned MAX_LIVE_BLOCKS = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ffpra_pkg::req_t in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ffpra_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned PW  = $clog2(PAGES);
  localparam int unsigned CW  = $clog2(PAGES + 1);
  localparam int unsigned BW  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned LW  = $clog2(MAX_LIVE_BLOCKS + 1);
  localparam int unsigned DW  = ffpra_pkg::DivW;
  localparam int unsigned PRW = CW + BW;

  localparam logic [CW-1:0]  PagesC = CW'(PAGES);
  localparam logic [BW:0]    PbC    = (BW + 1)'(PAGE_BYTES);
  localparam logic [DW-1:0]  PbD    = DW'(PAGE_BYTES);
  localparam logic [LW-1:0]  MaxLv  = LW'(MAX_LIVE_BLOCKS);

  typedef enum logic [11:0] {
    StClear = 12'b000000000001,
    StIdle  = 12'b000000000010,
    StCount = 12'b000000000100,
    StDec   = 12'b000000001000,
    StAFind = 12'b000000010000,
    StAMark = 12'b000000100000,
    StFRd   = 12'b000001000000,
    StFChk  = 12'b000010000000,
    StFRel  = 12'b000100000000,
    StQScan = 12'b001000000000,
    StMul   = 12'b010000000000,
    StRes   = 12'b100000000000
  } state_e;

  state_e state_q;

  logic [1:0]       pmem [PAGES];
  logic [CW-1:0]    lmem [PAGES];
  logic [1:0]       rd_q;
  logic [CW-1:0]    lrd_q;

  logic [PW-1:0]    clr_q;
  logic [LW-1:0]    live_q;
  logic [1:0]       mode_q;
  logic [DW-1:0]    acc_q;
  logic [22:0]      tgt_q;
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    need_q;
  logic [CW-1:0]    scan_q;
  logic             pv_q;
  logic [CW-1:0]    run_q;
  logic [CW-1:0]    best_q;
  logic [PW-1:0]    start_q;
  logic [PW-1:0]    mk_q;
  logic [PW-1:0]    lst_q;
  logic [PW-1:0]    pg_q;
  logic [CW-1:0]    op_q;
  logic [1:0]       st_q;
  logic [PRW-1:0]   prod_q;
  logic             out_valid_q;
  ffpra_pkg::rsp_t  out_q;

  logic             we;
  logic [PW-1:0]    wa;
  logic [1:0]       wd;
  logic             lwe;
  logic [PW-1:0]    ra;
  logic [CW-1:0]    nrun;
  logic [CW-1:0]    nbest;
  logic [CW-1:0]    found_start;
  logic [CW:0]      rel_end;
  logic [22:0]      sat_res;

  assign nrun        = run_q + CW'(1);
  assign nbest       = (nrun > best_q) ? nrun : best_q;
  assign found_start = scan_q - need_q;
  assign rel_end     = {1'b0, CW'(pg_q)} + {1'b0, lrd_q};
  assign sat_res     = (prod_q > PRW'(ffpra_pkg::ResultMax)) ? ffpra_pkg::ResultMax
                                                             : prod_q[22:0];

  always_comb begin
    we  = 1'b0;
    wa  = mk_q;
    wd  = 2'b00;
    lwe = 1'b0;
    ra  = scan_q[PW-1:0];
    case (state_q)
      StClear: begin
        we = 1'b1;
        wa = clr_q;
      end
      StAMark: begin
        we  = 1'b1;
        wd  = {1'b1, mk_q == start_q};
        lwe = (mk_q == start_q);
      end
      StFRel: begin
        we = 1'b1;
      end
      StFRd: begin
        ra = pg_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pmem[wa] <= wd;
    end
    if (lwe) begin
      lmem[start_q] <= need_q;
    end
    rd_q  <= pmem[ra];
    lrd_q <= lmem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StRes) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(PAGES - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            mode_q <= in_req_i.mode;
            acc_q  <= '0;
            cnt_q  <= '0;
            scan_q <= '0;
            pv_q   <= 1'b0;
            run_q  <= '0;
            best_q <= '0;
            case (in_req_i.mode)
              ffpra_pkg::ModeAlloc: begin
                tgt_q   <= in_req_i.size_bytes;
                state_q <= StCount;
              end
              ffpra_pkg::ModeFree: begin
                tgt_q   <= {1'b0, in_req_i.address};
                state_q <= StCount;
              end
              ffpra_pkg::ModeQuery: begin
                state_q <= StQScan;
              end
              default: begin
                op_q    <= '0;
                st_q    <= ffpra_pkg::StatusOk;
                state_q <= StMul;
              end
            endcase
          end
        end
        StCount: begin
          if (acc_q >= DW'(tgt_q) || cnt_q == PagesC) begin
            state_q <= StDec;
          end else begin
            acc_q <= acc_q + PbD;
            cnt_q <= cnt_q + CW'(1);
          end
        end
        StDec: begin
          op_q <= '0;
          if (mode_q == ffpra_pkg::ModeAlloc) begin
            if (cnt_q == '0 || acc_q < DW'(tgt_q) || live_q >= MaxLv) begin
              st_q    <= ffpra_pkg::StatusAllocFail;
              state_q <= StMul;
            end else begin
              need_q  <= cnt_q;
              state_q <= StAFind;
            end
          end else begin
            if (acc_q != DW'(tgt_q) || cnt_q == PagesC) begin
              st_q    <= ffpra_pkg::StatusFreeReject;
              state_q <= StMul;
            end else begin
              pg_q    <= cnt_q[PW-1:0];
              state_q <= StFRd;
            end
          end
        end
        StAFind: begin
          if (scan_q < PagesC) begin
            scan_q <= scan_q + CW'(1);
          end
          pv_q <= (scan_q < PagesC);
          if (pv_q && !rd_q[1] && nrun >= need_q) begin
            start_q <= found_start[PW-1:0];
            mk_q    <= found_start[PW-1:0];
            lst_q   <= PW'(found_start + need_q - CW'(1));
            state_q <= StAMark;
          end else begin
            if (pv_q) begin
              run_q <= rd_q[1] ? '0 : nrun;
            end
            if (pv_q && scan_q == PagesC) begin
              op_q    <= '0;
              st_q    <= ffpra_pkg::StatusAllocFail;
              state_q <= StMul;
            end
          end
        end
        StAMark: begin
          mk_q <= mk_q + PW'(1);
          if (mk_q == lst_q) begin
            live_q  <= live_q + LW'(1);
            op_q    <= CW'(start_q);
            st_q    <= ffpra_pkg::StatusOk;
            state_q <= StMul;
          end
        end
        StFRd: begin
          state_q <= StFChk;
        end
        StFChk: begin
          if (!rd_q[0]) begin
            op_q    <= '0;
            st_q    <= ffpra_pkg::StatusFreeReject;
            state_q <= StMul;
          end else begin
            mk_q    <= pg_q;
            lst_q   <= (rel_end > (CW + 1)'(PAGES)) ? PW'(PAGES - 1)
                                                    : PW'(rel_end - (CW + 1)'(1));
            state_q <= StFRel;
          end
        end
        StFRel: begin
          mk_q <= mk_q + PW'(1);
          if (mk_q == lst_q) begin
            if (live_q != '0) begin
              live_q <= live_q - LW'(1);
            end
            op_q    <= '0;
            st_q    <= ffpra_pkg::StatusOk;
            state_q <= StMul;
          end
        end
        StQScan: begin
          if (scan_q < PagesC) begin
            scan_q <= scan_q + CW'(1);
          end
          pv_q <= (scan_q < PagesC);
          if (pv_q) begin
            run_q  <= rd_q[1] ? '0 : nrun;
            best_q <= rd_q[1] ? best_q : nbest;
          end
          if (pv_q && scan_q == PagesC) begin
            op_q    <= rd_q[1] ? best_q : nbest;
            st_q    <= ffpra_pkg::StatusOk;
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= PRW'(op_q) * PRW'(PbC);
          state_q <= StRes;
        end
        StRes: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.result_address <= sat_res;
            out_q.status         <= st_q;
            out_valid_q          <= 1'b1;
            state_q              <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ffpra_checker.sv
// Port-level checker for the first-fit page-run allocator, bound to its top level.
// Depends on ffpra_pkg and first_fit_page_run_allocator_defines.svh.
`default_nettype none
`include "first_fit_page_run_allocator_defines.svh"

module ffpra_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire ffpra_pkg::rsp_t out_rsp_o
);

  `FFPRA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "accepted request did not make the block busy")
  `FFPRA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled result changed or vanished")
  `FFPRA_ASSERT(a_status_code, out_valid_o |-> out_rsp_o.status != 2'd3, "unknown status code")
  `FFPRA_ASSERT(a_fail_zero, out_valid_o && out_rsp_o.status != ffpra_pkg::StatusOk |-> out_rsp_o.result_address == '0, "failed request returned a nonzero value")

endmodule

bind first_fit_page_run_allocator ffpra_checker u_ffpra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

FILE: sim/tb_first_fit_page_run_allocator.sv
// Testbench of the first-fit page-run allocator: directed and random requests, checked
// against a behavioral page map kept in the testbench.
// Depends on ffpra_pkg and first_fit_page_run_allocator.
`timescale 1ns / 100ps

module tb_first_fit_page_run_allocator;

  localparam int unsigned Pages     = 1024;
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned MaxLive   = 256;
  localparam logic [1:0]  ModeSpare = 2'd3;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ffpra_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ffpra_pkg::rsp_t out_rsp_o;

  first_fit_page_run_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bit          map_used [Pages];
  bit          map_head [Pages];
  int unsigned map_len  [Pages];
  int unsigned live_count;
  int unsigned live_starts[$];

  ffpra_pkg::rsp_t pending_rsp[$];
  int   mismatches;
  int   sent_count;
  int   rsp_count;
  int   ok_allocs;
  int   idle_cycles;
  int   stall_left = 0;
  bit   ready_for_stall;

  function automatic ffpra_pkg::rsp_t predict_request(ffpra_pkg::req_t r);
    ffpra_pkg::rsp_t o;
    longint      need;
    int unsigned p, start, best, run, page;
    bit          placed;
    o = '0;
    case (r.mode)
      ffpra_pkg::ModeAlloc: begin
        need = (longint'(r.size_bytes) + PageBytes - 1) / PageBytes;
        o.status = ffpra_pkg::StatusAllocFail;
        placed = 0;
        if (need != 0 && live_count < MaxLive && need <= Pages) begin
          p = 0;
          while (p < Pages && !placed) begin
            if (map_used[p]) begin
              p++;
            end else begin
              start = p;
              while (p < Pages && !map_used[p]) p++;
              if (p - start >= need) begin
                for (int i = 0; i < need; i++) map_used[start + i] = 1;
                map_head[start] = 1;
                map_len[start] = need;
                live_count++;
                live_starts.push_back(start);
                o.result_address = start * PageBytes;
                o.status = ffpra_pkg::StatusOk;
                placed = 1;
              end
            end
          end
        end
      end
      ffpra_pkg::ModeFree: begin
        page = r.address / PageBytes;
        if (r.address % PageBytes != 0 || page >= Pages || !map_head[page]) begin
          o.status = ffpra_pkg::StatusFreeReject;
        end else begin
          for (int i = 0; i < map_len[page] && page + i < Pages; i++) map_used[page + i] = 0;
          map_head[page] = 0;
          if (live_count > 0) live_count--;
          foreach (live_starts[k]) if (live_starts[k] == page) begin
            live_starts.delete(k);
            break;
          end
        end
      end
      ffpra_pkg::ModeQuery: begin
        best = 0;
        run = 0;
        for (int q = 0; q < Pages; q++) begin
          if (map_used[q]) run = 0;
          else begin
            run++;
            if (run > best) best = run;
          end
        end
        o.result_address = best * PageBytes;
        o.status = ffpra_pkg::StatusOk;
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic send_request(logic [1:0] mode, logic [22:0] size_b, logic [21:0] addr);
    ffpra_pkg::req_t r;
    int   gap;
    gap = $urandom_range(0, 4);
    r.mode = mode;
    r.size_bytes = size_b;
    r.address = addr;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_rsp.push_back(predict_request(r));
    if (r.mode == ffpra_pkg::ModeAlloc && pending_rsp[$].status == ffpra_pkg::StatusOk)
      ok_allocs++;
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    ffpra_pkg::rsp_t want;
    if (in_valid_i && !in_stall_o || out_valid_o && !out_stall_i) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %h", out_rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (want.result_address !== out_rsp_o.result_address ||
            want.status !== out_rsp_o.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                     want.result_address, want.status,
                     out_rsp_o.result_address, out_rsp_o.status);
        end
      end
    end
    if (ready_for_stall) begin
      if (out_valid_o && !out_stall_i) begin
        stall_left = $urandom_range(0, 4);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [21:0] pick_live_address();
    if (live_starts.size() == 0) return '0;
    return live_starts[$urandom_range(0, live_starts.size() - 1)] * PageBytes;
  endfunction

  task automatic test_edges();
    send_request(ffpra_pkg::ModeQuery, '0, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd0, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd4194305, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'h7FFFFF, 22'h3FFFFF);
    send_request(ffpra_pkg::ModeAlloc, 23'd4194304, '0);
    send_request(ffpra_pkg::ModeQuery, '0, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd1, '0);
    send_request(ffpra_pkg::ModeFree, '0, 22'd0);
    send_request(ffpra_pkg::ModeFree, '0, 22'd0);
    send_request(ffpra_pkg::ModeAlloc, 23'd1, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd4096, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd4097, '0);
    send_request(ffpra_pkg::ModeFree, '0, 22'd4097);
    send_request(ffpra_pkg::ModeFree, '0, 22'h3FFFFF);
    send_request(ffpra_pkg::ModeFree, '0, 22'd4096);
    send_request(ffpra_pkg::ModeAlloc, 23'd100, '0);
    send_request(ModeSpare, 23'h7FFFFF, 22'h3FFFFF);
    send_request(ffpra_pkg::ModeFree, '0, 22'd0);
    send_request(ffpra_pkg::ModeFree, '0, 22'd8192);
    send_request(ffpra_pkg::ModeQuery, '0, '0);
    send_request(ffpra_pkg::ModeFree, '0, 22'd4096);
    send_request(ffpra_pkg::ModeQuery, '0, '0);
  endtask

  task automatic test_block_limit();
    while (live_count < MaxLive) send_request(ffpra_pkg::ModeAlloc, 23'd1, '0);
    send_request(ffpra_pkg::ModeAlloc, 23'd1, '0);
    send_request(ffpra_pkg::ModeQuery, '0, '0);
    while (live_starts.size() > 0) send_request(ffpra_pkg::ModeFree, '0, pick_live_address());
  endtask

  task automatic test_random(int count);
    int          sel;
    logic [22:0] sz;
    logic [21:0] ad;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      ad = $urandom();
      sz = $urandom();
      if (sel < 45) begin
        sz = ($urandom_range(0, 9) == 0) ? sz : 23'($urandom_range(1, 16 * PageBytes));
        send_request(ffpra_pkg::ModeAlloc, sz, ad);
      end else if (sel < 80) begin
        send_request(ffpra_pkg::ModeFree, sz, live_starts.size() ? pick_live_address() : ad);
      end else if (sel < 88) begin
        send_request(ffpra_pkg::ModeFree, sz, ad);
      end else if (sel < 97) begin
        send_request(ffpra_pkg::ModeQuery, sz, ad);
      end else begin
        send_request(ModeSpare, sz, ad);
      end
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    mismatches = 0;
    sent_count = 0;
    rsp_count = 0;
    ok_allocs = 0;
    idle_cycles = 0;
    live_count = 0;
    ready_for_stall = 0;
    foreach (map_used[i]) begin
      map_used[i] = 0;
      map_head[i] = 0;
      map_len[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    ready_for_stall <= 1'b1;
    test_edges();
    test_block_limit();
    test_random(510);
    wait_drained();
    repeat (Pages + 64) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d responses, %0d successful allocations.",
             sent_count, rsp_count, ok_allocs);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Failures: %0d mismatches, %0d responses missing", mismatches,
               pending_rsp.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
